// ===== rtl/quoted_escape_decoder_utf8_core_macros.svh =====
// Assertion macros shared by the checker of the escape decoder.
`ifndef QUOTED_ESCAPE_DECODER_UTF8_CORE_MACROS_SVH
`define QUOTED_ESCAPE_DECODER_UTF8_CORE_MACROS_SVH

// Plain clocked property, disabled while reset is held.
`define QED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, disabled while reset is held.
`define QED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qed_pkg.sv =====
// Types, codes and helper functions of the quoted-string escape decoder.
`default_nettype none

package qed_pkg;

  // Error codes carried on the result
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrTrailBs   = 3'd1;
  localparam logic [2:0] ErrUnknown   = 3'd2;
  localparam logic [2:0] ErrHexTrunc  = 3'd3;
  localparam logic [2:0] ErrHexBad    = 3'd4;
  localparam logic [2:0] ErrUniTrunc  = 3'd5;
  localparam logic [2:0] ErrUniBad    = 3'd6;
  localparam logic [2:0] ErrSurrogate = 3'd7;

  // Characters that steer the decoder
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChU         = 8'h75;

  // One request to the output side: one to three bytes and their status
  typedef struct packed {
    logic [1:0] cnt;   // number of results, 1..3
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [2:0] err;
    logic       last;  // last mark of the final result
  } job_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Single-letter escape map: {valid, byte}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h6E:   r = {1'b1, 8'h0A};  // n
      8'h74:   r = {1'b1, 8'h09};  // t
      8'h72:   r = {1'b1, 8'h0D};  // r
      8'h5C:   r = {1'b1, 8'h5C};  // backslash
      8'h22:   r = {1'b1, 8'h22};  // double quote
      8'h2F:   r = {1'b1, 8'h2F};  // slash
      8'h30:   r = {1'b1, 8'h00};  // zero
      8'h61:   r = {1'b1, 8'h07};  // a
      8'h62:   r = {1'b1, 8'h08};  // b
      8'h66:   r = {1'b1, 8'h0C};  // f
      8'h76:   r = {1'b1, 8'h0B};  // v
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qed_front.sv =====
// Front end: takes input bytes, runs the escape state machine, issues requests.
`default_nettype none

module qed_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_last_i,
  output qed_pkg::job_t      job_o,
  output logic               push_o
);

  localparam logic [2:0] ModeNormal = 3'd0;
  localparam logic [2:0] ModeEscape = 3'd1;
  localparam logic [2:0] ModeHex    = 3'd2;
  localparam logic [2:0] ModeUni    = 3'd3;
  localparam logic [2:0] ModeDrop   = 3'd4;

  logic [2:0]  mode_q, mode_d;
  logic [2:0]  digits_q, digits_d;
  logic [15:0] acc_q, acc_d;
  logic        bad_q, bad_d;

  logic        accept;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic        uni;
  logic [2:0]  need;
  logic [2:0]  dig_nx;
  logic [15:0] acc_nx;
  logic        bad_nx;
  logic        is_sur;
  logic        emit;

  assign accept = in_valid_i && in_ready_i;
  assign hex    = qed_pkg::hex_digit(in_byte_i);
  assign esc    = qed_pkg::esc_map(in_byte_i);
  assign uni    = (mode_q == ModeUni);
  assign need   = uni ? 3'd4 : 3'd2;
  assign dig_nx = digits_q + 3'd1;
  assign acc_nx = hex[4] ? {acc_q[11:0], hex[3:0]} : acc_q;
  assign bad_nx = bad_q || !hex[4];
  assign is_sur = (acc_nx >= 16'hD800) && (acc_nx <= 16'hDFFF);

  // Next state and request
  always_comb begin
    mode_d   = mode_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    bad_d    = bad_q;
    emit     = 1'b0;
    job_o    = '{cnt: 2'd1, b0: 8'd0, b1: 8'd0, b2: 8'd0,
                 err: qed_pkg::ErrNone, last: in_last_i};
    case (mode_q)
      ModeDrop: begin
        if (in_last_i) mode_d = ModeNormal;
      end
      ModeEscape: begin
        if (esc[8]) begin
          emit     = 1'b1;
          job_o.b0 = esc[7:0];
          mode_d   = ModeNormal;
        end else if (in_byte_i == qed_pkg::ChX || in_byte_i == qed_pkg::ChU) begin
          digits_d = 3'd0;
          acc_d    = 16'd0;
          bad_d    = 1'b0;
          if (in_last_i) begin
            emit      = 1'b1;
            job_o.err = (in_byte_i == qed_pkg::ChX) ? qed_pkg::ErrHexTrunc
                                                   : qed_pkg::ErrUniTrunc;
            mode_d    = ModeNormal;
          end else begin
            mode_d = (in_byte_i == qed_pkg::ChX) ? ModeHex : ModeUni;
          end
        end else begin
          emit      = 1'b1;
          job_o.err = qed_pkg::ErrUnknown;
        end
      end
      ModeHex, ModeUni: begin
        digits_d = dig_nx;
        acc_d    = acc_nx;
        bad_d    = bad_nx;
        if (dig_nx < need) begin
          if (in_last_i) begin
            emit      = 1'b1;
            job_o.err = uni ? qed_pkg::ErrUniTrunc : qed_pkg::ErrHexTrunc;
          end
        end else if (bad_nx) begin
          emit      = 1'b1;
          job_o.err = uni ? qed_pkg::ErrUniBad : qed_pkg::ErrHexBad;
        end else if (!uni) begin
          emit     = 1'b1;
          job_o.b0 = acc_nx[7:0];
          mode_d   = ModeNormal;
          digits_d = 3'd0;
          acc_d    = 16'd0;
          bad_d    = 1'b0;
        end else if (is_sur) begin
          emit      = 1'b1;
          job_o.err = qed_pkg::ErrSurrogate;
        end else begin
          // UTF-8 encode of the code point
          emit     = 1'b1;
          mode_d   = ModeNormal;
          digits_d = 3'd0;
          acc_d    = 16'd0;
          bad_d    = 1'b0;
          if (acc_nx < 16'h0080) begin
            job_o.b0 = acc_nx[7:0];
          end else if (acc_nx < 16'h0800) begin
            job_o.cnt = 2'd2;
            job_o.b0  = 8'hC0 | {3'd0, acc_nx[10:6]};
            job_o.b1  = 8'h80 | {2'd0, acc_nx[5:0]};
          end else begin
            job_o.cnt = 2'd3;
            job_o.b0  = 8'hE0 | {4'd0, acc_nx[15:12]};
            job_o.b1  = 8'h80 | {2'd0, acc_nx[11:6]};
            job_o.b2  = 8'h80 | {2'd0, acc_nx[5:0]};
          end
        end
      end
      default: begin
        mode_d = ModeNormal;
        if (in_byte_i == qed_pkg::ChBackslash) begin
          if (in_last_i) begin
            emit      = 1'b1;
            job_o.err = qed_pkg::ErrTrailBs;
          end else begin
            mode_d = ModeEscape;
          end
        end else begin
          emit     = 1'b1;
          job_o.b0 = in_byte_i;
        end
      end
    endcase
    // Any error: single result with last set, then drop until last mark
    if (emit && job_o.err != qed_pkg::ErrNone) begin
      job_o.cnt  = 2'd1;
      job_o.b0   = 8'd0;
      job_o.last = 1'b1;
      digits_d   = 3'd0;
      acc_d      = 16'd0;
      bad_d      = 1'b0;
      mode_d     = in_last_i ? ModeNormal : ModeDrop;
    end
  end

  assign push_o = accept && emit;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeNormal;
      digits_q <= 3'd0;
      acc_q    <= 16'd0;
      bad_q    <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      bad_q    <= bad_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qed_fifo.sv =====
// Short request queue between the front end and the output stage.
`default_nettype none

module qed_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  qed_pkg::job_t      push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output qed_pkg::job_t      head_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  qed_pkg::job_t   mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
      if (do_pop)  rd_q <= (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qed_back.sv =====
// Output stage: unrolls each request into results through an output register.
`default_nettype none

module qed_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  qed_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [2:0]         out_err_o,
  output logic               out_last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic [2:0] err_q;
  logic       last_q;
  logic [1:0] idx_q;
  logic       load;
  logic       final_res;
  logic [7:0] sel_byte;

  assign load      = job_valid_i && (!valid_q || out_ready_i);
  assign final_res = (idx_q == job_i.cnt - 2'd1);
  assign pop_o     = load && final_res;

  // Pick the byte of the current result
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = job_i.b0;
      2'd1:    sel_byte = job_i.b1;
      default: sel_byte = job_i.b2;
    endcase
  end

  // Result index within the request and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
      if (load)             valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      err_q  <= job_i.err;
      last_q <= final_res && job_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_err_o   = err_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/quoted_escape_decoder_utf8_core.sv =====
// Each emitting byte queues a request; the output register then loads its first result.
// Throughput: one input byte per cycle; one result per cycle unless the output stalls, so
//   a unicode escape giving three UTF-8 bytes holds the output register for three results.
// The request queue (QueueDepth entries) absorbs those bursts; input stalls when full.
// Reset: asynchronous, active low; decoder returns to pass-through mode, queue empty.
`default_nettype none

module quoted_escape_decoder_utf8_core #(
  parameter int unsigned QueueDepth = 4  // at least 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,   // [2:0] error_code
  output logic            m_axis_tlast
);

  qed_pkg::job_t push_job, head_job;
  logic          push, full, pop, head_valid;

  assign s_axis_tready = !full;

  // Byte classification and escape decode
  qed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .job_o      (push_job),
    .push_o     (push)
  );

  // Request queue
  qed_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_job)
  );

  // Result emission
  qed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/qed_checker.sv =====
// Port-level checks of the escape decoder, bound to the top level.
`default_nettype none
`include "quoted_escape_decoder_utf8_core_macros.svh"

module qed_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  logic        out_stall;
  logic [11:0] out_pay;
  logic        out_err;
  logic        in_x;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_pay   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_err   = m_axis_tvalid && (m_axis_tuser != qed_pkg::ErrNone);
  assign in_x      = $isunknown(s_axis_tdata) || $isunknown(s_axis_tlast);

  // A stalled result keeps its payload
  `QED_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_pay), "held result changed")

  // Error results carry a zero byte and close the string
  `QED_ASSERT_IMPL(a_err_form, out_err, m_axis_tdata == 8'd0 && m_axis_tlast, "bad error result")

  // Input backpressure only while results are pending at the output
  `QED_ASSERT_IMPL(a_stall_pending, !s_axis_tready, m_axis_tvalid, "stall with no result pending")

  // Offered requests carry known data and last mark
  `QED_ASSERT(a_in_known, s_axis_tvalid |-> !in_x, "unknown input request")

endmodule

bind quoted_escape_decoder_utf8_core qed_checker u_qed_checker (.*);

`default_nettype wire
